### hw/rtl/drrq_pkg.sv
// Shared types, constants and a helper function of the deduplicating release queue.
`default_nettype none

package drrq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int MAX_BURST   = 16;

   localparam int ID_W       = 32;
   localparam int TAG_W      = 32;
   localparam int TICK_W     = 16;
   localparam int RC_W       = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int BURST_W = $clog2(MAX_BURST + 1);
   localparam int LIM_W   = (RC_W > BURST_W) ? RC_W : BURST_W;

   // Request kinds.
   localparam logic [1:0] KIND_REG   = 2'd0;
   localparam logic [1:0] KIND_UNREG = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_TICKS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COUNT = 2'd2;

   // Result status codes.
   localparam logic STATUS_RELEASED = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ID_W-1:0]  unit_id;
      logic [TAG_W-1:0] request_tag;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [ID_W-1:0]  out_unit_id;
      logic [TAG_W-1:0] out_tag;
      logic             last;
   } rsp_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic capture;   // latch the key compare result
      logic occupied;  // cell lies below the fill count
      logic shift;     // take the upper neighbor's entry
      logic load;      // take the new entry
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_REJECT,
      ST_RELEASE
   } state_type;

   // Inclusive prefix OR from index 0 upward, built as a log-depth network.
   function automatic logic [QUEUE_DEPTH-1:0] prefix_or(input logic [QUEUE_DEPTH-1:0] v);
      logic [QUEUE_DEPTH-1:0] r;
      logic [QUEUE_DEPTH-1:0] p;
      r = v;
      for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
         p = r;
         for (int i = s; i < QUEUE_DEPTH; i++) begin
            r[i] = p[i] | p[i-s];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/drrq_cell.sv
// One queue slot: holds an id and tag, compares against the search key, shifts toward the head.
`default_nettype none

module drrq_cell (
   input  wire logic                        clock,
   input  wire drrq_pkg::cell_ctl_type      ctl,
   input  wire logic [drrq_pkg::ID_W-1:0]   key_id,
   input  wire logic [drrq_pkg::TAG_W-1:0]  new_tag,
   input  wire logic [drrq_pkg::ID_W-1:0]   up_id,
   input  wire logic [drrq_pkg::TAG_W-1:0]  up_tag,
   output logic      [drrq_pkg::ID_W-1:0]   id,
   output logic      [drrq_pkg::TAG_W-1:0]  tag,
   output logic                             match
);

   logic [drrq_pkg::ID_W-1:0]  id_ff;
   logic [drrq_pkg::TAG_W-1:0] tag_ff;
   logic                       match_ff;

   // Load has priority: the append slot may also lie in the shifting range.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         id_ff  <= key_id;
         tag_ff <= new_tag;
      end else if (ctl.shift) begin
         id_ff  <= up_id;
         tag_ff <= up_tag;
      end
      if (ctl.capture) begin
         match_ff <= ctl.occupied && (id_ff == key_id);
      end
   end

   assign id    = id_ff;
   assign tag   = tag_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

### hw/rtl/dedup_rate_limited_release_queue_top.sv
// Top level of the deduplicating, rate-limited release queue built as a chain of cells.
// A register or unregister request passes through accept, key search and update; a rejected
// register then goes through the reject state. A tick that releases a burst of n entries gives
// n results, one per cycle while the receiver does not stall; the head cell feeds the output.
// Reset clears the fill count, tick counter and output valid and sets the configuration to
// enable off and a delay and release count of one; cells keep data.
`default_nettype none

module dedup_rate_limited_release_queue_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire drrq_pkg::req_type                  req_data,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output drrq_pkg::rsp_type                       rsp_data,
   // Configuration write port.
   input  wire logic                               csr_we,
   input  wire logic [drrq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [drrq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH = drrq_pkg::QUEUE_DEPTH;
   localparam int CNT_W = drrq_pkg::CNT_W;
   localparam int BRST_W = drrq_pkg::BURST_W;

   // Configuration registers.
   logic                            enable_ff;
   logic [drrq_pkg::TICK_W-1:0]     delay_ff;
   logic [drrq_pkg::RC_W-1:0]       release_count_ff;

   // Sequencer state.
   drrq_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [drrq_pkg::TICK_W-1:0]     ticks_ff, ticks_in;
   logic [BRST_W-1:0]               burst_ff, burst_in;

   // The request being worked on.
   logic [1:0]                      kind_ff, kind_in;
   logic [drrq_pkg::ID_W-1:0]       key_ff, key_in;
   logic [drrq_pkg::TAG_W-1:0]      tag_ff, tag_in;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   drrq_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   // Cell chain signals.
   logic [drrq_pkg::ID_W-1:0]       cell_id  [DEPTH];
   logic [drrq_pkg::TAG_W-1:0]      cell_tag [DEPTH];
   logic [DEPTH-1:0]                cell_match;
   logic [DEPTH-1:0]                match_pre;
   drrq_pkg::cell_ctl_type          cell_ctl [DEPTH];

   logic                            req_accept;
   logic                            rsp_free;
   logic                            had_match;
   logic                            capture;
   logic                            shift_all;
   logic                            shift_match;
   logic                            load_new;
   logic [CNT_W-1:0]                wr_pos;
   logic [drrq_pkg::TICK_W-1:0]     ticks_next;
   logic [BRST_W-1:0]               limit;
   logic                            burst_last;

   assign req_stall  = (state_ff != drrq_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The matched slot and everything above it move one place toward the head.
   assign had_match = |cell_match;
   assign match_pre = drrq_pkg::prefix_or(cell_match);

   // Saturating tick count as it will be after this tick.
   assign ticks_next = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;

   // Burst size is the release count clamped to the largest burst.
   always_comb begin
      if (drrq_pkg::LIM_W'(release_count_ff) > drrq_pkg::LIM_W'(drrq_pkg::MAX_BURST)) begin
         limit = BRST_W'(drrq_pkg::MAX_BURST);
      end else begin
         limit = BRST_W'(release_count_ff);
      end
   end

   // A burst ends on its last allowed entry or when the queue runs dry.
   assign burst_last = (burst_ff == BRST_W'(1)) || (count_ff == CNT_W'(1));

   // Configuration writes; indexes past the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         delay_ff         <= drrq_pkg::TICK_W'(1);
         release_count_ff <= drrq_pkg::RC_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            drrq_pkg::CSR_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            drrq_pkg::CSR_DELAY_TICKS: begin
               delay_ff <= csr_wdata[drrq_pkg::TICK_W-1:0];
            end
            drrq_pkg::CSR_RELEASE_COUNT: begin
               release_count_ff <= csr_wdata[drrq_pkg::RC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drrq_pkg::ST_IDLE;
         count_ff     <= '0;
         ticks_ff     <= '0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ticks_ff     <= ticks_in;
         burst_ff     <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      tag_ff      <= tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: next state and cell controls.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ticks_in     = ticks_ff;
      burst_in     = burst_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      capture      = 1'b0;
      shift_all    = 1'b0;
      shift_match  = 1'b0;
      load_new     = 1'b0;
      wr_pos       = count_ff;

      case (state_ff)
         drrq_pkg::ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_data.kind;
               key_in  = req_data.unit_id;
               tag_in  = req_data.request_tag;
               if (req_data.kind == drrq_pkg::KIND_REG ||
                   req_data.kind == drrq_pkg::KIND_UNREG) begin
                  state_in = drrq_pkg::ST_SEARCH;
               end else if (req_data.kind == drrq_pkg::KIND_TICK) begin
                  ticks_in = ticks_next;
                  if (enable_ff && (ticks_next >= delay_ff)) begin
                     // The counter clears even when nothing leaves.
                     ticks_in = '0;
                     burst_in = limit;
                     if (limit != '0 && count_ff != '0) begin
                        state_in = drrq_pkg::ST_RELEASE;
                     end
                  end
               end
            end
         end

         drrq_pkg::ST_SEARCH: begin
            capture  = 1'b1;
            state_in = drrq_pkg::ST_UPDATE;
         end

         drrq_pkg::ST_UPDATE: begin
            state_in = drrq_pkg::ST_IDLE;
            if (kind_ff == drrq_pkg::KIND_REG) begin
               if (!had_match && count_ff == CNT_W'(DEPTH)) begin
                  // A new id into a full queue is turned away unchanged.
                  state_in = drrq_pkg::ST_REJECT;
               end else begin
                  shift_match = had_match;
                  load_new    = 1'b1;
                  wr_pos      = had_match ? count_ff - 1'b1 : count_ff;
                  count_in    = had_match ? count_ff : count_ff + 1'b1;
               end
            end else begin
               shift_match = had_match;
               if (had_match) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end

         drrq_pkg::ST_REJECT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = drrq_pkg::STATUS_REJECTED;
               rsp_data_in.out_unit_id = key_ff;
               rsp_data_in.out_tag     = tag_ff;
               rsp_data_in.last        = 1'b1;
               state_in                = drrq_pkg::ST_IDLE;
            end
         end

         drrq_pkg::ST_RELEASE: begin
            if (rsp_free) begin
               // The head cell leaves and the whole chain moves down one place.
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = drrq_pkg::STATUS_RELEASED;
               rsp_data_in.out_unit_id = cell_id[0];
               rsp_data_in.out_tag     = cell_tag[0];
               rsp_data_in.last        = burst_last;
               shift_all               = 1'b1;
               count_in                = count_ff - 1'b1;
               burst_in                = burst_ff - 1'b1;
               if (burst_last) begin
                  state_in = drrq_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = drrq_pkg::ST_IDLE;
         end
      endcase
   end

   // The chain of cells; cell 0 is the head of the queue.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [drrq_pkg::ID_W-1:0]  up_id;
      logic [drrq_pkg::TAG_W-1:0] up_tag;

      if (g == DEPTH - 1) begin : g_top
         assign up_id  = cell_id[g];
         assign up_tag = cell_tag[g];
      end else begin : g_mid
         assign up_id  = cell_id[g+1];
         assign up_tag = cell_tag[g+1];
      end

      assign cell_ctl[g].capture  = capture;
      assign cell_ctl[g].occupied = (CNT_W'(g) < count_ff);
      assign cell_ctl[g].shift    = shift_all || (shift_match && match_pre[g]);
      assign cell_ctl[g].load     = load_new && (wr_pos == CNT_W'(g));

      drrq_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[g]),
         .key_id  (key_ff),
         .new_tag (tag_ff),
         .up_id   (up_id),
         .up_tag  (up_tag),
         .id      (cell_id[g]),
         .tag     (cell_tag[g]),
         .match   (cell_match[g])
      );
   end

endmodule

`default_nettype wire

### hw/rtl/drrq_checker.sv
// Port-level checks on the release queue top level, attached by bind.
`default_nettype none

module drrq_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire drrq_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire drrq_pkg::rsp_type rsp_data
);

   // A result held back by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A rejected register is always the only result of its request.
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == drrq_pkg::STATUS_REJECTED |-> rsp_data.last)
      else $error("reject result without last mark");

   // An unregister request never starts a new result in the next cycle.
   a_unreg_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == drrq_pkg::KIND_UNREG
      |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("result appeared after unregister request");

endmodule

bind dedup_rate_limited_release_queue_top drrq_checker u_drrq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the deduplicating, rate-limited release queue.
`default_nettype none

module tb_top;
   import drrq_pkg::*;

   // The request kind that the block must ignore has no name in the package.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Quiet cycles granted after the last expected result before the block counts
   // as idle. This covers a full burst of MAX_BURST results plus the accept, search
   // and update steps of a register or unregister.
   localparam int SETTLE_CYCLES = 40;

   // Cycles without any accepted request, result or register write before the
   // run is declared hung. The longest legitimate quiet stretch is the receiver
   // hold-off.
   localparam int WATCHDOG_LIMIT = 3000;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_REQUESTS  = 20;
   localparam int POOL_SIZE       = 128;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dedup_rate_limited_release_queue_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted state of the block. Slot 0 of the queues is the head entry.
   logic [ID_W-1:0]   queued_ids[$];
   logic [TAG_W-1:0]  queued_tags[$];
   logic [TICK_W-1:0] tick_count = '0;
   logic              cfg_enable = 1'b0;
   logic [TICK_W-1:0] cfg_delay = 16'd1;
   logic [RC_W-1:0]   cfg_burst = 5'd1;

   // Results that the block still owes, oldest first.
   rsp_type pending_results[$];

   int mismatch_count = 0;

   // Idling controls. The percentages give the chance that an idle burst starts
   // on a given request or cycle; zero means the side never idles.
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int hold_left = 0;

   logic [ID_W-1:0] id_pool[POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor.
   // ---------------------------------------------------------------------------

   // Removes the entry of one id, closing the gap; tells whether it was queued.
   function automatic bit drop_id(input logic [ID_W-1:0] id);
      for (int i = 0; i < queued_ids.size(); i++) begin
         if (queued_ids[i] == id) begin
            queued_ids.delete(i);
            queued_tags.delete(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Updates the predicted state for one accepted request and queues the
   // results that it must cause.
   function automatic void predict_request(input req_type r);
      rsp_type want;
      int      limit;
      int      count;
      case (r.kind)
         KIND_REG: begin
            if (!drop_id(r.unit_id) && queued_ids.size() >= QUEUE_DEPTH) begin
               want.status      = STATUS_REJECTED;
               want.out_unit_id = r.unit_id;
               want.out_tag     = r.request_tag;
               want.last        = 1'b1;
               pending_results  = {pending_results, want};
            end else begin
               queued_ids  = {queued_ids, r.unit_id};
               queued_tags = {queued_tags, r.request_tag};
            end
         end
         KIND_UNREG: begin
            void'(drop_id(r.unit_id));
         end
         KIND_TICK: begin
            if (tick_count != {TICK_W{1'b1}}) begin
               tick_count = tick_count + 1'b1;
            end
            if (cfg_enable && tick_count >= cfg_delay) begin
               tick_count = '0;
               limit = (cfg_burst > MAX_BURST) ? MAX_BURST : int'(cfg_burst);
               count = (queued_ids.size() < limit) ? queued_ids.size() : limit;
               for (int i = 0; i < count; i++) begin
                  want.status      = STATUS_RELEASED;
                  want.out_unit_id = queued_ids[0];
                  want.out_tag     = queued_tags[0];
                  queued_ids.delete(0);
                  queued_tags.delete(0);
                  want.last        = (i == count - 1);
                  pending_results  = {pending_results, want};
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_type make_req(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                        input logic [TAG_W-1:0] tag);
      req_type r;
      r.kind        = kind;
      r.unit_id     = id;
      r.request_tag = tag;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------

   // Offers one request and returns at the rising edge that accepts it. Valid is
   // left high so that back-to-back requests need no second assignment within
   // one time step; whoever idles next lowers it.
   task automatic send_req(input req_type r);
      int gap;
      @(negedge clock);
      if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predict_request(r);
   endtask

   // Stops offering requests until every predicted result has arrived, then
   // gives the block time to finish any work that causes no result.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_ENABLE:        cfg_enable = value[0];
         CSR_DELAY_TICKS:   cfg_delay  = value[TICK_W-1:0];
         CSR_RELEASE_COUNT: cfg_burst  = value[RC_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Registers are only ever written once the block has gone idle.
   task automatic configure(input logic en, input logic [TICK_W-1:0] delay,
                            input logic [RC_W-1:0] burst);
      wait_quiet();
      write_csr(CSR_ENABLE, CSR_DATA_W'(en));
      write_csr(CSR_DELAY_TICKS, CSR_DATA_W'(delay));
      write_csr(CSR_RELEASE_COUNT, CSR_DATA_W'(burst));
   endtask

   // Empties the queue with full bursts on every tick.
   task automatic flush_queue();
      configure(1'b1, 16'd0, 5'd16);
      while (queued_ids.size() != 0) begin
         send_req(make_req(KIND_TICK, $urandom(), $urandom()));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side.
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // The receiver stalls in random bursts, and holds off for a long stretch
   // whenever a test loads hold_left.
   initial begin : sink_stall
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            stall_left = $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %b, want %b", rsp_data.status, want.status));
            end
            if (rsp_data.out_unit_id !== want.out_unit_id) begin
               report_mismatch($sformatf("unit id %h, want %h",
                                         rsp_data.out_unit_id, want.out_unit_id));
            end
            if (rsp_data.out_tag !== want.out_tag) begin
               report_mismatch($sformatf("tag %h, want %h", rsp_data.out_tag, want.out_tag));
            end
            if (rsp_data.last !== want.last) begin
               report_mismatch($sformatf("last %b, want %b", rsp_data.last, want.last));
            end
         end
      end
   end

   // The watchdog restarts its count on every accepted request, result or
   // register write, so only a real hang ends the run here.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // Field extremes, every kind, the dedup move to the tail, an unregister of an
   // absent id, a tick while disabled, zero delay, a release with an empty
   // queue, a release count of zero and a release count above the burst limit.
   task automatic test_basic_ops();
      send_req(make_req(KIND_REG, 32'h0000_0000, 32'h0000_0000));
      send_req(make_req(KIND_REG, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_req(make_req(KIND_REG, 32'h5A5A_5A5A, 32'h1234_5678));
      send_req(make_req(KIND_REG, 32'h0000_0000, 32'hA5A5_A5A5));
      send_req(make_req(KIND_UNREG, 32'h0000_1234, 32'h0));
      send_req(make_req(KIND_UNREG, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_req(make_req(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_req(make_req(KIND_TICK, 32'h0, 32'h0));

      // Zero delay: each tick releases, and a tick with nothing queued is silent.
      configure(1'b1, 16'd0, 5'd16);
      send_req(make_req(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_req(make_req(KIND_TICK, 32'h0, 32'h0));

      // A release count of zero clears the counter but lets nothing out.
      configure(1'b1, 16'd0, 5'd0);
      send_req(make_req(KIND_REG, 32'h0000_0001, $urandom()));
      send_req(make_req(KIND_REG, 32'h0000_0002, $urandom()));
      send_req(make_req(KIND_TICK, 32'h0, 32'h0));

      // The largest release count is capped at the burst limit.
      configure(1'b1, 16'd2, 5'd31);
      for (int i = 0; i < 16; i++) begin
         send_req(make_req(KIND_REG, 32'hC000_0000 + i, $urandom()));
      end
      repeat (4) send_req(make_req(KIND_TICK, $urandom(), $urandom()));
   endtask

   // Fills the queue, checks rejection and the re-register that always fits,
   // then releases it all while the receiver holds off so that the block backs
   // up into its request side.
   task automatic test_full_queue();
      int n;
      flush_queue();
      configure(1'b0, 16'd1, 5'd16);
      n = 0;
      while (queued_ids.size() < QUEUE_DEPTH) begin
         send_req(make_req(KIND_REG, 32'h8000_0000 + n, $urandom()));
         n++;
      end
      send_req(make_req(KIND_REG, 32'h7FFF_FFFF, $urandom()));
      send_req(make_req(KIND_REG, queued_ids[0], $urandom()));
      send_req(make_req(KIND_UNREG, 32'h8000_0005, $urandom()));
      send_req(make_req(KIND_REG, 32'h7FFF_FFFF, $urandom()));
      send_req(make_req(KIND_REG, 32'h0000_0001, $urandom()));

      configure(1'b1, 16'd0, 5'd16);
      hold_left = HOLD_OFF_CYCLES;
      for (int i = 0; i < 12; i++) begin
         send_req(make_req(KIND_TICK, $urandom(), $urandom()));
         send_req(make_req(KIND_REG, 32'h9000_0000 + i, $urandom()));
      end
      wait_quiet();
   endtask

   // Ticks keep counting while the block is disabled, so the first tick after
   // enabling releases at once when the count has already passed the delay.
   task automatic test_disabled_count();
      flush_queue();
      configure(1'b0, 16'd12, 5'd2);
      for (int i = 0; i < 3; i++) begin
         send_req(make_req(KIND_REG, $urandom(), $urandom()));
      end
      repeat (16) send_req(make_req(KIND_TICK, $urandom(), $urandom()));
      configure(1'b1, 16'd12, 5'd2);
      send_req(make_req(KIND_TICK, $urandom(), $urandom()));
      send_req(make_req(KIND_TICK, $urandom(), $urandom()));
   endtask

   function automatic req_type random_request(input int pool_n);
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.request_tag = $urandom();
      if ($urandom_range(0, 9) == 0) begin
         r.unit_id = $urandom();
      end else begin
         r.unit_id = id_pool[$urandom_range(0, pool_n - 1)];
      end
      if (pick < 45) begin
         r.kind = KIND_REG;
      end else if (pick < 65) begin
         r.kind = KIND_UNREG;
      end else if (pick < 96) begin
         r.kind = KIND_TICK;
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   // Phases of random requests, each under its own settings. Most phases draw
   // ids from a small pool so that dedup and unregister hit often; one draws
   // from a large pool so that most registers add a new entry. The last phase
   // runs without idling on either side.
   task automatic test_random_traffic();
      logic              en;
      logic [TICK_W-1:0] delay;
      logic [RC_W-1:0]   burst;
      int                pool_n;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0:       delay = 16'd0;
            1:       delay = 16'd1;
            2:       delay = (phase == 2) ? 16'hFFFF : 16'd3;
            default: delay = TICK_W'($urandom_range(0, 6));
         endcase
         en     = (phase != 1);
         burst  = (phase == 0) ? 5'd31 : RC_W'($urandom_range(0, 20));
         pool_n = (phase == 1) ? 96 : $urandom_range(4, 16);
         configure(en, delay, burst);
         if (phase == RANDOM_PHASES - 1) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end else begin
            src_idle_pct  = $urandom_range(0, 2) * 15;
            sink_idle_pct = $urandom_range(0, 2) * 10;
         end
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            // Now and then the sender waits for every owed result to drain.
            if ($urandom_range(0, 39) == 0) begin
               wait_quiet();
            end
            send_req(random_request(pool_n));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence of the run.
   // ---------------------------------------------------------------------------

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         id_pool[i] = $urandom();
      end
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      src_idle_pct  = 20;
      sink_idle_pct = 20;
      test_full_queue();
      test_disabled_count();
      test_random_traffic();

      src_idle_pct  = 0;
      sink_idle_pct = 0;
      wait_quiet();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
